// ===== rtl/core/halo_grid_cell_walker_core_macros.svh =====
// assertion macros for the halo grid cell walker
`ifndef HALO_GRID_CELL_WALKER_CORE_MACROS_SVH
`define HALO_GRID_CELL_WALKER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, off while rst_n is low
`define HGCW_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hgcw assertion failed");

// next-cycle implication
`define HGCW_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hgcw assertion failed");

`else

`define HGCW_ASSERT_IMP(lbl, ante, cons)
`define HGCW_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/hgcw_pkg.sv =====
// shared types, widths and grid geometry helpers for the cell walker
package hgcw_pkg;

    localparam int CUR_W  = 16;
    localparam int X_W    = 8;
    localparam int Y_W    = 16;
    localparam int SIDE_W = 8;
    localparam int W_W    = 9;
    localparam int PROD_W = 17;

    localparam logic [SIDE_W-1:0] MAX_SIDE = 8'd254;

    typedef enum logic [1:0] {
        OP_RESTART = 2'd0,
        OP_ADVANCE = 2'd1,
        OP_JUMP    = 2'd2,
        OP_HOLD    = 2'd3
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [CUR_W-1:0] jump_index;
    } cmd_t;

    typedef struct packed {
        logic [SIDE_W-1:0] interior_width;
        logic [SIDE_W-1:0] interior_height;
        logic [2:0]        walk_select;
    } cfg_t;

    typedef struct packed {
        logic [W_W-1:0]    w;
        logic [W_W-1:0]    t;
        logic [W_W-1:0]    w_m1;
        logic [W_W-1:0]    w_m2;
        logic [W_W-1:0]    t_m1;
        logic [W_W-1:0]    t_m2;
        logic [PROD_W-1:0] wt;
        logic [CUR_W-1:0]  last_all;
        logic [CUR_W-1:0]  row_top;
        logic [CUR_W-1:0]  last_in;
    } geom_t;

    typedef struct packed {
        logic [CUR_W-1:0] cell_index;
        logic [X_W-1:0]   cell_x;
        logic [X_W-1:0]   cell_y;
        logic             walk_valid;
        logic [CUR_W-1:0] left_neighbor;
        logic [CUR_W-1:0] right_neighbor;
        logic [CUR_W-1:0] upper_neighbor;
        logic [CUR_W-1:0] lower_neighbor;
    } res_t;

    function automatic logic [SIDE_W-1:0] clamp_side(logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        r = v;
        if (v == '0)
            r = 8'd1;
        else if (v > MAX_SIDE)
            r = MAX_SIDE;
        return r;
    endfunction

    function automatic geom_t calc_geom(logic [SIDE_W-1:0] iw, logic [SIDE_W-1:0] ih);
        geom_t             g;
        logic [PROD_W-1:0] prod;
        g.w    = {1'b0, clamp_side(iw)} + 9'd2;
        g.t    = {1'b0, clamp_side(ih)} + 9'd2;
        g.w_m1 = g.w - 9'd1;
        g.w_m2 = g.w - 9'd2;
        g.t_m1 = g.t - 9'd1;
        g.t_m2 = g.t - 9'd2;
        prod   = {8'd0, g.w} * {8'd0, g.t};
        g.wt       = prod;
        g.last_all = CUR_W'(prod - 17'd1);
        g.row_top  = CUR_W'(prod - {8'd0, g.w});
        g.last_in  = CUR_W'(prod - {8'd0, g.w} - 17'd2);
        return g;
    endfunction

endpackage

// ===== rtl/core/hgcw_div.sv =====
// radix-2 restoring divider: linear index into row and column
module hgcw_div
    import hgcw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [CUR_W-1:0] dividend,
    input  logic [W_W-1:0]   divisor,
    output logic             done,
    output logic [Y_W-1:0]   quotient,
    output logic [X_W-1:0]   remainder
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [3:0]       count_reg, count_next;
    logic [CUR_W-1:0] quot_reg, quot_next;
    logic [W_W-1:0]   rem_reg, rem_next;
    logic [W_W-1:0]   dvs_reg, dvs_next;
    logic [W_W:0]     shifted;
    logic             fits;

    assign shifted = {rem_reg, quot_reg[CUR_W-1]};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            quot_next  = dividend;
            rem_next   = '0;
            dvs_next   = divisor;
        end
        else if (busy_reg)
        begin
            // remainder stays below the divisor, so the top bit drops out
            if (fits)
                rem_next = W_W'(shifted - {1'b0, dvs_reg});
            else
                rem_next = shifted[W_W-1:0];
            quot_next  = {quot_reg[CUR_W-2:0], fits};
            count_next = count_reg + 4'd1;
            if (count_reg == 4'd15)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg[X_W-1:0];

endmodule

// ===== rtl/core/hgcw_front.sv =====
// front end: takes commands, decodes the mode and queues them
module hgcw_front
    import hgcw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       in_mode,
    input  logic [CUR_W-1:0] in_jump,
    output logic             q_valid,
    output cmd_t             q_cmd,
    input  logic             q_pop
);

    localparam logic [1:0] MODE_RESTART = 2'd0;
    localparam logic [1:0] MODE_ADVANCE = 2'd1;
    localparam logic [1:0] MODE_JUMP    = 2'd2;

    cmd_t       fifo_mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    cmd_t       cmd_in;

    always_comb
    begin
        cmd_in.jump_index = in_jump;
        case (in_mode)
            MODE_RESTART: cmd_in.op = OP_RESTART;
            MODE_ADVANCE: cmd_in.op = OP_ADVANCE;
            MODE_JUMP:    cmd_in.op = OP_JUMP;
            default:      cmd_in.op = OP_HOLD;
        endcase
    end

    assign in_ready = count_reg != 2'd2;
    assign q_valid  = count_reg != 2'd0;
    assign push     = in_valid && in_ready;
    assign q_cmd    = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= cmd_in;
    end

endmodule

// ===== rtl/core/hgcw_back.sv =====
// back end: walk state, coordinate tracking, neighbour calculation and result register
`include "halo_grid_cell_walker_core_macros.svh"

module hgcw_back
    import hgcw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic geom_wr,
    input  logic q_valid,
    input  cmd_t q_cmd,
    output logic q_pop,
    output res_t res,
    output logic res_valid,
    input  logic res_ready
);

    localparam logic [2:0] WALK_ALL      = 3'd0;
    localparam logic [2:0] WALK_INTERIOR = 3'd1;
    localparam logic [2:0] WALK_CORNERS  = 3'd2;
    localparam logic [2:0] WALK_BOTTOM   = 3'd3;
    localparam logic [2:0] WALK_RIGHT    = 3'd4;
    localparam logic [2:0] WALK_TOP      = 3'd5;
    localparam logic [2:0] WALK_LEFT     = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EXEC = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    geom_t            geom_reg;
    op_t              op_reg;
    logic [CUR_W-1:0] cur_reg;
    logic [X_W-1:0]   x_reg;
    logic [Y_W-1:0]   y_reg;
    logic             valid_reg;
    logic             stale_reg;
    res_t             res_reg, res_next;
    logic             res_valid_reg;

    logic             exec_go;
    logic             div_start;
    logic [CUR_W-1:0] div_dividend;
    logic             div_done;
    logic [Y_W-1:0]   div_quot;
    logic [X_W-1:0]   div_rem;

    logic [CUR_W:0]   inc_sum;
    logic             inc_wrap;
    logic [CUR_W-1:0] inc_cur;
    logic [X_W-1:0]   inc_x;
    logic [Y_W-1:0]   inc_y;

    logic [CUR_W-1:0] cur_n;
    logic [X_W-1:0]   x_n;
    logic [Y_W-1:0]   y_n;
    logic             valid_n;
    logic [CUR_W-1:0] w_ext;

    hgcw_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (geom_reg.w),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign exec_go = !res_valid_reg || res_ready;
    assign w_ext   = {7'd0, geom_reg.w};

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        q_pop        = 1'b0;
        div_start    = 1'b0;
        div_dividend = cur_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_cmd.op == OP_JUMP)
                    begin
                        div_start    = 1'b1;
                        div_dividend = q_cmd.jump_index;
                        state_next   = ST_DIV;
                    end
                    else if (stale_reg && (q_cmd.op inside {OP_ADVANCE, OP_HOLD}))
                    begin
                        // grid was resized, coordinates must be rebuilt first
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                        state_next = ST_EXEC;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (exec_go)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // single step forward, carrying into the next row
    always_comb
    begin
        inc_sum  = {1'b0, cur_reg} + 17'd1;
        inc_wrap = ({1'b0, x_reg} + 9'd1) == geom_reg.w;
        inc_cur  = inc_sum[CUR_W-1:0];
        if (inc_sum[CUR_W])
        begin
            inc_x = '0;
            inc_y = '0;
        end
        else if (inc_wrap)
        begin
            inc_x = '0;
            inc_y = y_reg + 16'd1;
        end
        else
        begin
            inc_x = x_reg + 8'd1;
            inc_y = y_reg;
        end
    end

    // next walk position
    always_comb
    begin
        cur_n   = cur_reg;
        x_n     = x_reg;
        y_n     = y_reg;
        valid_n = valid_reg;
        case (op_reg)
            OP_RESTART:
            begin
                valid_n = 1'b1;
                case (cfg.walk_select)
                    WALK_INTERIOR:
                    begin
                        cur_n = w_ext + 16'd1;
                        x_n   = 8'd1;
                        y_n   = 16'd1;
                    end
                    WALK_BOTTOM:
                    begin
                        cur_n = 16'd1;
                        x_n   = 8'd1;
                        y_n   = '0;
                    end
                    WALK_RIGHT:
                    begin
                        cur_n = {6'd0, geom_reg.w, 1'b0} - 16'd1;
                        x_n   = geom_reg.w_m1[X_W-1:0];
                        y_n   = 16'd1;
                    end
                    WALK_TOP:
                    begin
                        cur_n = geom_reg.row_top + 16'd1;
                        x_n   = 8'd1;
                        y_n   = {7'd0, geom_reg.t_m1};
                    end
                    WALK_LEFT:
                    begin
                        cur_n = w_ext;
                        x_n   = '0;
                        y_n   = 16'd1;
                    end
                    default:
                    begin
                        cur_n = '0;
                        x_n   = '0;
                        y_n   = '0;
                    end
                endcase
            end
            OP_ADVANCE:
            begin
                if (valid_reg)
                begin
                    case (cfg.walk_select)
                        WALK_ALL:
                        begin
                            if (cur_reg >= geom_reg.last_all)
                                valid_n = 1'b0;
                            else
                            begin
                                cur_n = inc_cur;
                                x_n   = inc_x;
                                y_n   = inc_y;
                            end
                        end
                        WALK_INTERIOR:
                        begin
                            if (cur_reg >= geom_reg.last_in)
                                valid_n = 1'b0;
                            else if ({1'b0, x_reg} == geom_reg.w_m2)
                            begin
                                // skip right halo and left halo of the next row
                                cur_n = cur_reg + 16'd3;
                                x_n   = 8'd1;
                                y_n   = y_reg + 16'd1;
                            end
                            else
                            begin
                                cur_n = inc_cur;
                                x_n   = inc_x;
                                y_n   = inc_y;
                            end
                        end
                        WALK_CORNERS:
                        begin
                            if (cur_reg == geom_reg.last_all)
                                valid_n = 1'b0;
                            else if (cur_reg == '0)
                            begin
                                cur_n = {7'd0, geom_reg.w_m1};
                                x_n   = geom_reg.w_m1[X_W-1:0];
                                y_n   = '0;
                            end
                            else if ({1'b0, x_reg} == geom_reg.w_m1)
                            begin
                                cur_n = geom_reg.row_top;
                                x_n   = '0;
                                y_n   = {7'd0, geom_reg.t_m1};
                            end
                            else
                            begin
                                cur_n = geom_reg.last_all;
                                x_n   = geom_reg.w_m1[X_W-1:0];
                                y_n   = {7'd0, geom_reg.t_m1};
                            end
                        end
                        WALK_BOTTOM, WALK_TOP:
                        begin
                            if ({1'b0, x_reg} >= geom_reg.w_m2)
                                valid_n = 1'b0;
                            else
                            begin
                                cur_n = inc_cur;
                                x_n   = inc_x;
                                y_n   = inc_y;
                            end
                        end
                        WALK_RIGHT, WALK_LEFT:
                        begin
                            if (y_reg >= {7'd0, geom_reg.t_m2})
                                valid_n = 1'b0;
                            else
                            begin
                                cur_n = cur_reg + w_ext;
                                y_n   = y_reg + 16'd1;
                            end
                        end
                        default: valid_n = valid_reg;
                    endcase
                end
            end
            default: valid_n = valid_reg;
        endcase
    end

    // result word with neighbours clamped at the grid edge
    always_comb
    begin
        res_next.cell_index     = cur_n;
        res_next.cell_x         = x_n;
        res_next.cell_y         = y_n[X_W-1:0];
        res_next.walk_valid     = valid_n;
        res_next.left_neighbor  = (x_n == '0) ? cur_n : cur_n - 16'd1;
        res_next.right_neighbor = ({1'b0, x_n} == geom_reg.w_m1) ? cur_n : cur_n + 16'd1;
        res_next.upper_neighbor = (y_n == {7'd0, geom_reg.t_m1}) ? cur_n : cur_n + w_ext;
        res_next.lower_neighbor = (y_n == '0) ? cur_n : cur_n - w_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            geom_reg      <= calc_geom(8'd1, 8'd1);
            cur_reg       <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            valid_reg     <= 1'b1;
            stale_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            geom_reg  <= calc_geom(cfg.interior_width, cfg.interior_height);
            if (state_reg == ST_IDLE && q_valid && q_cmd.op == OP_JUMP)
            begin
                cur_reg   <= q_cmd.jump_index;
                valid_reg <= {1'b0, q_cmd.jump_index} < geom_reg.wt;
            end
            if (state_reg == ST_DIV && div_done)
            begin
                x_reg <= div_rem;
                y_reg <= div_quot;
            end
            if (state_reg == ST_EXEC && exec_go)
            begin
                cur_reg   <= cur_n;
                x_reg     <= x_n;
                y_reg     <= y_n;
                valid_reg <= valid_n;
            end
            if (geom_wr)
                stale_reg <= 1'b1;
            else if ((state_reg == ST_DIV && div_done) || (state_reg == ST_EXEC && exec_go))
                stale_reg <= 1'b0;
            if (state_reg == ST_EXEC && exec_go)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && q_valid)
            op_reg <= q_cmd.op;
        if (state_reg == ST_EXEC && exec_go)
            res_reg <= res_next;
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

    `HGCW_ASSERT_IMP(a_col_in_row, !stale_reg, {1'b0, x_reg} < geom_reg.w)
    `HGCW_ASSERT_NXT(a_restart_valid, state_reg == ST_EXEC && exec_go && op_reg == OP_RESTART, valid_reg)
    `HGCW_ASSERT_IMP(a_result_from_exec, $rose(res_valid_reg), $past(state_reg) == ST_EXEC)
    `HGCW_ASSERT_NXT(a_jump_loads, state_reg == ST_IDLE && q_valid && q_cmd.op == OP_JUMP, cur_reg == $past(q_cmd.jump_index))

endmodule

// ===== rtl/core/halo_grid_cell_walker_core.sv =====
// top level of the halo grid cell walker: configuration registers, front and back ends
//
// Walks the cells of a row-major grid with a one-cell ghost halo (row width is the
// interior width plus 2, row 0 and column 0 are halo). Each command transaction
// (restart, advance, jump, hold) gives one result transaction with the linear index,
// its column and row, the walk valid flag and the four neighbour indices clamped at the
// grid edge. A restart or an advance goes from the head of the command queue through the
// ST_EXEC state to the result register. A jump, and the first advance or hold after the
// interior width or height is written, first runs the index through a one-bit-per-cycle
// divider by the row width in the ST_DIV state. A two-entry command queue lets new
// commands arrive while the walker is busy, and the result register holds a finished
// result while the next command is taken in. Configuration is to be written only while
// no command is in flight; the block itself does not enforce this.
module halo_grid_cell_walker_core
    import hgcw_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // configuration
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [7:0]   cfg_data,
    // commands
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [15:0] jump_index
    input  logic [1:0]   s_tuser,   // [1:0] mode
    // results
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [103:0] m_tdata    // [15:0] cell_index, [23:16] cell_x, [31:24] cell_y,
                                    // [32] walk_valid, [48:33] left_neighbor,
                                    // [64:49] right_neighbor, [80:65] upper_neighbor,
                                    // [96:81] lower_neighbor, [103:97] zero
);

    localparam logic [1:0] REG_IW   = 2'd0;
    localparam logic [1:0] REG_IH   = 2'd1;
    localparam logic [1:0] REG_WALK = 2'd2;

    cfg_t cfg_reg;
    logic geom_wr;
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;
    res_t res;

    assign geom_wr = cfg_we && (cfg_index == REG_IW || cfg_index == REG_IH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.interior_width  <= 8'd1;
            cfg_reg.interior_height <= 8'd1;
            cfg_reg.walk_select     <= 3'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IW:   cfg_reg.interior_width  <= cfg_data;
                REG_IH:   cfg_reg.interior_height <= cfg_data;
                REG_WALK: cfg_reg.walk_select     <= cfg_data[2:0];
                default:  cfg_reg <= cfg_reg;
            endcase
        end
    end

    hgcw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_mode  (s_tuser),
        .in_jump  (s_tdata),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .q_pop    (q_pop)
    );

    hgcw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .geom_wr   (geom_wr),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .res       (res),
        .res_valid (m_tvalid),
        .res_ready (m_tready)
    );

    assign m_tdata = {7'd0, res.lower_neighbor, res.upper_neighbor, res.right_neighbor,
                      res.left_neighbor, res.walk_valid, res.cell_y, res.cell_x,
                      res.cell_index};

endmodule
